### src/sbsh_pkg.sv
`timescale 1ns / 1ps
// Shared types, command/status structs and SHA-256 constants for the byte stream hasher.
// No dependencies; used by the controller, datapath and top level.
package sbsh_pkg;

    localparam int unsigned ROUNDS = 64;
    localparam int unsigned DIGEST_WORDS = 8;

    localparam logic [5:0] ROUND_LAST = 6'(ROUNDS - 1);
    localparam logic [2:0] WORD_LAST = 3'(DIGEST_WORDS - 1);
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] FILL_LEN_START = 6'd56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] HASH_INIT [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_ONE,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAD,
        PH_FINAL
    } phase_t;

    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_ONE,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic       shift_byte;
        byte_sel_t  byte_sel;
        logic       len_load;
        logic       work_load;
        logic       round_en;
        logic [5:0] round_idx;
        logic       hash_add;
        logic       count_inc;
        logic       count_clear;
        logic       hash_rotate;
        logic       hash_reload;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_len_start;
    } dp_status_t;

endpackage

### src/sbsh_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM: byte intake, padding sequence, round counting and digest output.
// Depends on sbsh_pkg; drives sbsh_datapath through dp_cmd_t.
module sbsh_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                byte_present,
    input  logic                end_of_message,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          word_index,
    output logic                last_word,
    input  sbsh_pkg::dp_status_t status,
    output sbsh_pkg::dp_cmd_t   cmd
);

    sbsh_pkg::state_t state_reg, state_next;
    sbsh_pkg::phase_t phase_reg, phase_next;
    logic             eom_reg, eom_next;
    logic [5:0]       round_reg, round_next;
    logic [2:0]       word_reg, word_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbsh_pkg::ST_IDLE;
            phase_reg <= sbsh_pkg::PH_DATA;
            eom_reg   <= 1'b0;
            round_reg <= '0;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            eom_reg   <= eom_next;
            round_reg <= round_next;
            word_reg  <= word_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        eom_next   = eom_reg;
        round_next = round_reg;
        word_next  = word_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        cmd.byte_sel  = sbsh_pkg::SEL_INPUT;
        cmd.round_idx = round_reg;

        case (state_reg)
            sbsh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        cmd.shift_byte = 1'b1;
                        if (status.fill_last)
                        begin
                            cmd.work_load = 1'b1;
                            phase_next    = sbsh_pkg::PH_DATA;
                            eom_next      = end_of_message;
                            round_next    = '0;
                            state_next    = sbsh_pkg::ST_ROUND;
                        end
                        else if (end_of_message)
                        begin
                            state_next = sbsh_pkg::ST_PAD_ONE;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = sbsh_pkg::ST_PAD_ONE;
                    end
                end
            end

            sbsh_pkg::ST_PAD_ONE:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = sbsh_pkg::SEL_ONE;
                cmd.len_load   = 1'b1;
                eom_next       = 1'b0;
                if (status.fill_last)
                begin
                    cmd.work_load = 1'b1;
                    phase_next    = sbsh_pkg::PH_PAD;
                    round_next    = '0;
                    state_next    = sbsh_pkg::ST_ROUND;
                end
                else
                begin
                    state_next = sbsh_pkg::ST_PAD_ZERO;
                end
            end

            sbsh_pkg::ST_PAD_ZERO:
            begin
                if (status.fill_len_start)
                begin
                    state_next = sbsh_pkg::ST_PAD_LEN;
                end
                else
                begin
                    cmd.shift_byte = 1'b1;
                    cmd.byte_sel   = sbsh_pkg::SEL_ZERO;
                    if (status.fill_last)
                    begin
                        cmd.work_load = 1'b1;
                        phase_next    = sbsh_pkg::PH_PAD;
                        round_next    = '0;
                        state_next    = sbsh_pkg::ST_ROUND;
                    end
                end
            end

            sbsh_pkg::ST_PAD_LEN:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = sbsh_pkg::SEL_LEN;
                if (status.fill_last)
                begin
                    cmd.work_load = 1'b1;
                    phase_next    = sbsh_pkg::PH_FINAL;
                    round_next    = '0;
                    state_next    = sbsh_pkg::ST_ROUND;
                end
            end

            sbsh_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == sbsh_pkg::ROUND_LAST)
                begin
                    state_next = sbsh_pkg::ST_UPDATE;
                end
            end

            sbsh_pkg::ST_UPDATE:
            begin
                cmd.hash_add = 1'b1;
                case (phase_reg)
                    sbsh_pkg::PH_DATA:
                    begin
                        cmd.count_inc = 1'b1;
                        state_next    = eom_reg ? sbsh_pkg::ST_PAD_ONE : sbsh_pkg::ST_IDLE;
                    end
                    sbsh_pkg::PH_PAD:
                    begin
                        state_next = sbsh_pkg::ST_PAD_ZERO;
                    end
                    sbsh_pkg::PH_FINAL:
                    begin
                        word_next  = '0;
                        state_next = sbsh_pkg::ST_EMIT;
                    end
                    default:
                    begin
                        state_next = sbsh_pkg::ST_IDLE;
                    end
                endcase
            end

            sbsh_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.hash_rotate = 1'b1;
                    word_next       = word_reg + 3'd1;
                    if (word_reg == sbsh_pkg::WORD_LAST)
                    begin
                        cmd.hash_reload = 1'b1;
                        cmd.count_clear = 1'b1;
                        state_next      = sbsh_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sbsh_pkg::ST_IDLE;
            end
        endcase
    end

    assign word_index = word_reg;
    assign last_word  = (word_reg == sbsh_pkg::WORD_LAST);

endmodule

### src/sbsh_datapath.sv
`timescale 1ns / 1ps
// Datapath: 64-byte buffer doubling as the schedule window, round logic, hash state,
// fill and block counters, length shifter. Depends on sbsh_pkg; driven by sbsh_ctrl.
module sbsh_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           data_byte,
    input  sbsh_pkg::dp_cmd_t    cmd,
    output sbsh_pkg::dp_status_t status,
    output logic [31:0]          digest_word
);

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // Word i of the window sits at win_reg[511-32*i -: 32]; word 0 is the oldest.
    logic [511:0] win_reg;
    logic [63:0]  len_reg;
    logic [5:0]   fill_reg;
    logic [54:0]  count_reg;
    logic [31:0]  hash_reg [8];
    logic [31:0]  work_reg [8];

    logic [7:0]   byte_mux;
    logic [31:0]  w_cur;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  ch;
    logic [31:0]  maj;

    always_comb
    begin
        case (cmd.byte_sel)
            sbsh_pkg::SEL_INPUT: byte_mux = data_byte;
            sbsh_pkg::SEL_ONE:   byte_mux = sbsh_pkg::PAD_BYTE;
            sbsh_pkg::SEL_ZERO:  byte_mux = 8'h00;
            sbsh_pkg::SEL_LEN:   byte_mux = len_reg[63:56];
            default:             byte_mux = 8'h00;
        endcase
    end

    assign w_cur = win_reg[511:480];
    assign w_new = small_sigma1(win_reg[63:32]) + win_reg[223:192]
                 + small_sigma0(win_reg[479:448]) + w_cur;

    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch
               + sbsh_pkg::ROUND_K[cmd.round_idx] + w_cur;
    assign t2  = big_sigma0(work_reg[0]) + maj;

    always_ff @(posedge clk)
    begin
        if (cmd.shift_byte)
        begin
            win_reg <= {win_reg[503:0], byte_mux};
        end
        else if (cmd.round_en)
        begin
            win_reg <= {win_reg[479:0], w_new};
        end

        if (cmd.len_load)
        begin
            len_reg <= {count_reg, fill_reg, 3'b000};
        end
        else if (cmd.shift_byte && (cmd.byte_sel == sbsh_pkg::SEL_LEN))
        begin
            len_reg <= {len_reg[55:0], 8'h00};
        end

        if (cmd.work_load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            work_reg[0] <= t1 + t2;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[5] <= work_reg[4];
            work_reg[6] <= work_reg[5];
            work_reg[7] <= work_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sbsh_pkg::HASH_INIT[i];
            end
        end
        else
        begin
            if (cmd.shift_byte)
            begin
                fill_reg <= fill_reg + 6'd1;
            end

            if (cmd.count_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + 55'd1;
            end

            if (cmd.hash_reload)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= sbsh_pkg::HASH_INIT[i];
                end
            end
            else if (cmd.hash_add)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
                end
            end
            else if (cmd.hash_rotate)
            begin
                for (int i = 0; i < 7; i++)
                begin
                    hash_reg[i] <= hash_reg[i + 1];
                end
                hash_reg[7] <= hash_reg[0];
            end
        end
    end

    assign status.fill_last      = (fill_reg == sbsh_pkg::FILL_LAST);
    assign status.fill_len_start = (fill_reg == sbsh_pkg::FILL_LEN_START);
    assign digest_word           = hash_reg[0];

endmodule

### src/sha256_byte_stream_hasher_top.sv
`timescale 1ns / 1ps
// SHA-256 byte stream hasher, top level.
// Depends on sbsh_pkg, sbsh_ctrl and sbsh_datapath.
//
// Input channel (in_valid/in_ready): one transaction carries data_byte, byte_present and
// end_of_message. The 64th byte of a block starts compression: 64 rounds at one round
// per cycle, then an update step that adds into the hash state. in_ready is low while
// a block compresses, while padding runs and while the digest goes out.
// end_of_message pads by shifting bytes into the buffer in turn: 0x80, zeros and the
// 8-byte bit count. When 56 or more bytes are pending the count does not fit and an
// extra block is needed; a 64th byte on the same transaction has its block compressed
// first, before the padding starts.
// Output channel (out_valid/out_ready): eight transactions, word_index 0 to 7, last_word
// on the eighth. Each word is offered in the cycle after the previous one is taken;
// a stall on out_ready simply holds the current word. After the eighth word the hash
// state is reloaded with the initial values and the block is ready for a new message.
// Reset loads the initial hash values and clears the byte and block counts.
module sha256_byte_stream_hasher_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sbsh_pkg::dp_cmd_t    cmd;
    sbsh_pkg::dp_status_t status;

    sbsh_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .word_index     (word_index),
        .last_word      (last_word),
        .status         (status),
        .cmd            (cmd)
    );

    sbsh_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule

### src/sbsh_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the SHA-256 byte stream hasher, bound to the top level.
// Depends only on the top level's ports.
module sbsh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
        else $error("output transaction dropped or changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while digest is going out");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            out_valid && (word_index == $past(word_index) + 3'd1))
        else $error("digest words out of order");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> in_ready && !out_valid)
        else $error("not ready for a new message after the digest");

endmodule

bind sha256_byte_stream_hasher_top sbsh_checker u_sbsh_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);

### verif/sbsh_digest_check.sv
`timescale 1ns / 1ps
// Digest checker for the SHA-256 byte stream hasher: watches both channels, predicts
// each digest from the accepted bytes and compares every word taken from the output.
// Stand-alone; instantiated by the testbench top beside the block.
module sbsh_digest_check
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          words_due
);

    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_entry_t;

    logic [31:0]   hash_state [8];
    logic [7:0]    msg_buf [64];
    int            fill_bytes;
    logic [63:0]   done_bits;
    digest_entry_t digest_due [$];
    int            mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, w2, w15, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                wt = w[t];
            else
            begin
                w2  = w[(t - 2) & 15];
                w15 = w[(t - 15) & 15];
                wt  = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w[(t - 7) & 15]
                    + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w[t & 15];
                w[t & 15] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endfunction

    // 0x80, zeros, then the 64-bit bit count; a second block when the count will not fit
    function automatic void pad_and_finish();
        logic [63:0] total;
        int          i;
        total = done_bits + 64'(fill_bytes) * 64'd8;
        i = fill_bytes;
        msg_buf[i] = 8'h80;
        i = i + 1;
        if (fill_bytes >= 56)
        begin
            while (i < 64)
            begin
                msg_buf[i] = 8'h00;
                i = i + 1;
            end
            compress_block();
            i = 0;
        end
        while (i < 56)
        begin
            msg_buf[i] = 8'h00;
            i = i + 1;
        end
        for (int k = 0; k < 8; k++)
            msg_buf[63 - k] = total[8*k +: 8];
        compress_block();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: digest mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_entry_t exp_w;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                hash_state[i] = H_START[i];
            fill_bytes = 0;
            done_bits  = '0;
            digest_due.delete();
            words_due <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digest_due.size() == 0)
                    report_mismatch("unexpected word", digest_word, 32'h0);
                else
                begin
                    exp_w = digest_due.pop_front();
                    if (digest_word !== exp_w.word)
                        report_mismatch("digest_word", digest_word, exp_w.word);
                    if (word_index !== exp_w.idx)
                        report_mismatch("word_index", 32'(word_index), 32'(exp_w.idx));
                    if (last_word !== exp_w.last)
                        report_mismatch("last_word", 32'(last_word), 32'(exp_w.last));
                end
            end
            if (in_valid && in_ready)
            begin
                if (byte_present)
                begin
                    msg_buf[fill_bytes] = data_byte;
                    fill_bytes = fill_bytes + 1;
                    if (fill_bytes == 64)
                    begin
                        compress_block();
                        done_bits  = done_bits + 64'd512;
                        fill_bytes = 0;
                    end
                end
                if (end_of_message)
                begin
                    pad_and_finish();
                    for (int j = 0; j < 8; j++)
                    begin
                        exp_w.word = hash_state[j];
                        exp_w.idx  = 3'(j);
                        exp_w.last = (j == 7);
                        digest_due.push_back(exp_w);
                    end
                    for (int i = 0; i < 8; i++)
                        hash_state[i] = H_START[i];
                    fill_bytes = 0;
                    done_bits  = '0;
                end
            end
            words_due <= digest_due.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the SHA-256 byte stream hasher: drives messages of random and
// block-boundary lengths under three idling regimes and gives the verdict.
// Depends on sha256_byte_stream_hasher_top and sbsh_digest_check.
module testbench;

    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 800;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        hold_req = 1'b0;

    int fail_count;
    int words_due;
    int send_idle_pct = 27;
    int recv_idle_pct = 75;
    int items_sent = 0;
    int bytes_sent = 0;
    int msgs_sent = 0;
    int filler_sent = 0;

    always #10 clk = ~clk;

    sha256_byte_stream_hasher_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    sbsh_digest_check checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .fail_count     (fail_count),
        .words_due      (words_due)
    );

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        bit held;
        int hold_left;
        held = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        byte_present   <= present;
        end_of_message <= eom;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (present || eom)
            items_sent++;
        else
            filler_sent++;
        if (present)
            bytes_sent++;
        if (eom)
            msgs_sent++;
    endtask

    task automatic send_filler();
        send_item(8'($urandom), 1'b0, 1'b0);
    endtask

    // len bytes; with tail set the last byte rides on the end-of-message transaction
    task automatic send_message(input int len, input bit tail);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(15) == 0)
                send_filler();
            send_item(8'($urandom), 1'b1, tail && (i == len - 1));
        end
        if (!tail || len == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int pick_length();
        int mode;
        mode = $urandom_range(9);
        if (mode < 4)
            return $urandom_range(12);
        if (mode < 7)
        begin
            case ($urandom_range(10))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 62;
                4: return 63;
                5: return 64;
                6: return 65;
                7: return 119;
                8: return 120;
                9: return 127;
                default: return 128;
            endcase
        end
        return $urandom_range(140);
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, filler before an empty end, short messages, byte extremes
        send_item(8'h00, 1'b0, 1'b1);
        send_filler();
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_filler();
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= 2 * RANDOM_ITEMS / 3)
            begin
                if (send_idle_pct != 0)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req <= 1'b1;
                end
            end
            else if (items_sent >= RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 27;
            end
            send_message(pick_length(), $urandom_range(1));
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (words_due != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Hashed %0d messages, %0d bytes, %0d filler transactions,", msgs_sent,
                 bytes_sent, filler_sent);
        $display("over three idling regimes with one long output hold-off.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sha256_byte_stream_hasher_top.f
src/sbsh_pkg.sv
src/sbsh_ctrl.sv
src/sbsh_datapath.sv
src/sha256_byte_stream_hasher_top.sv
src/sbsh_checker.sv
verif/sbsh_digest_check.sv
verif/testbench.sv
